@@ rtl/core/pcs_pkg.sv @@
// shared types, constants and helpers for the password character statistics block
// no dependencies; imported by every module under rtl/core

package pcs_pkg;

  // counter width and length histogram size
  localparam int unsigned CountBits  = 32;
  localparam int unsigned TopLenBin  = 30;
  localparam int unsigned LenW       = $clog2(TopLenBin + 1);

  // field widths
  localparam int unsigned ActionW    = 2;
  localparam int unsigned CharW      = 8;
  localparam int unsigned BankW      = 2;
  localparam int unsigned IdxW       = 7;
  localparam int unsigned ClassW     = 3;
  localparam int unsigned SlotW      = 7;

  // character table and class layout
  localparam int unsigned TableSize  = 89;
  localparam int unsigned ClassCount = 5;
  localparam int unsigned SymCount   = 27;
  localparam int unsigned SymBase    = 62;
  localparam int unsigned UpperBase  = 26;
  localparam int unsigned DigitBase  = 52;
  localparam int unsigned ZeroSlot   = 61;

  // character table memory
  localparam int unsigned ADepth     = TableSize;
  localparam int unsigned AAddrW     = $clog2(ADepth);

  // shared memory: length bins first, then the class counters
  localparam int unsigned ClassBase  = TopLenBin + 1;
  localparam int unsigned BDepth     = ClassBase + ClassCount;
  localparam int unsigned BAddrW     = $clog2(BDepth);

  // ascii anchors
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChOne   = 8'h31;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // symbols in table order, slot SymBase + position
  localparam logic [CharW-1:0] SymTab [SymCount] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29, 8'h2d,
    8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3a, 8'h3b, 8'h22, 8'h27, 8'h3c, 8'h3e, 8'h2e,
    8'h2f, 8'h3f, 8'h7e, 8'h60, 8'h20
  };

  typedef enum logic [ActionW-1:0] {
    ActFeed = 2'd0,
    ActEnd  = 2'd1,
    ActRead = 2'd2,
    ActNone = 2'd3
  } action_e;

  typedef enum logic [BankW-1:0] {
    BankLen   = 2'd0,
    BankClass = 2'd1,
    BankChar  = 2'd2,
    BankNone  = 2'd3
  } bank_e;

  typedef enum logic [ClassW-1:0] {
    ClsLower = 3'd0,
    ClsUpper = 3'd1,
    ClsDigit = 3'd2,
    ClsSym   = 3'd3,
    ClsOther = 3'd4
  } class_e;

  typedef struct packed {
    class_e           cls;
    logic             hit;
    logic [SlotW-1:0] slot;
  } cls_info_t;

  // saturating increment
  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

endpackage

@@ rtl/core/password_character_statistics.sv @@
// top level of the password character statistics block
// depends on pcs_pkg, pcs_classify and pcs_cnt_mem

// Counts password text one byte per word. A feed word classifies the byte
// (lower, upper, digit, symbol, other), bumps that class counter and, for the
// 89 tabulated characters, a per-character counter; an end word bumps the
// length bin for the password just ended (lengths saturate at the top bin);
// a read word returns one counter of the chosen bank, out-of-range reads give
// zero. All counters saturate at all ones. Throughput is one word per cycle
// while the output is not stalled: every word takes a read-modify-write
// through two counter memories (character counters, and length bins shared
// with class counters), each with one read and one write port; a same-entry
// write on the read edge is forwarded. A word passes the read-modify-write
// stage, then the output register. After reset every counter reads zero at
// once (per-entry valid bits), so there is no clearing pass. A waiting
// result stalls the input only while the read-modify-write stage is full.

module password_character_statistics import pcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic [CharW-1:0]     char_code_i,
  input  logic [BankW-1:0]     bank_i,
  input  logic [IdxW-1:0]      entry_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ClassW-1:0]    char_class_o,
  output logic                 table_hit_o,
  output logic [SlotW-1:0]     table_slot_o,
  output logic [LenW-1:0]      length_bin_o,
  output logic [CountBits-1:0] count_value_o
);

  // which memory feeds count_value
  typedef enum logic [1:0] {
    SelNone = 2'd0,
    SelA    = 2'd1,
    SelB    = 2'd2
  } sel_e;

  // handshake
  logic in_fire;
  logic s1_adv;

  // classifier
  cls_info_t info;

  // issue-side decode
  action_e           act;
  bank_e             bank;
  logic              a_rd_en, b_rd_en;
  logic [AAddrW-1:0] a_rd_addr;
  logic [BAddrW-1:0] b_rd_addr;
  logic              a_wr_need, b_wr_need;
  sel_e              sel_d;
  class_e            cls_d;
  logic              hit_d;
  logic [SlotW-1:0]  slot_d;
  logic [LenW-1:0]   bin_d;
  logic [LenW-1:0]   len_d, len_q;

  // read-modify-write stage
  logic              s1_vld_q;
  logic              s1_a_wr_q, s1_b_wr_q;
  logic [AAddrW-1:0] s1_a_addr_q;
  logic [BAddrW-1:0] s1_b_addr_q;
  sel_e              s1_sel_q;
  class_e            s1_cls_q;
  logic              s1_hit_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic [LenW-1:0]   s1_bin_q;

  logic [CountBits-1:0] a_rd_data, b_rd_data;
  logic [CountBits-1:0] a_wr_data, b_wr_data;
  logic                 a_wr_en, b_wr_en;
  logic [CountBits-1:0] value;

  // output register
  logic                 out_vld_q;
  class_e               out_cls_q;
  logic                 out_hit_q;
  logic [SlotW-1:0]     out_slot_q;
  logic [LenW-1:0]      out_bin_q;
  logic [CountBits-1:0] out_val_q;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  pcs_classify u_classify (
    .char_i (char_code_i),
    .info_o (info)
  );

  // decode the incoming word and pick the counters it touches
  always_comb begin
    act       = action_e'(action_i);
    bank      = bank_e'(bank_i);
    a_rd_en   = 1'b0;
    b_rd_en   = 1'b0;
    a_rd_addr = '0;
    b_rd_addr = '0;
    a_wr_need = 1'b0;
    b_wr_need = 1'b0;
    sel_d     = SelNone;
    cls_d     = ClsLower;
    hit_d     = 1'b0;
    slot_d    = '0;
    bin_d     = '0;
    len_d     = len_q;
    case (act)
      ActFeed: begin
        cls_d     = info.cls;
        hit_d     = info.hit;
        slot_d    = info.slot;
        b_rd_en   = 1'b1;
        b_wr_need = 1'b1;
        b_rd_addr = BAddrW'(ClassBase) + BAddrW'(info.cls);
        a_rd_en   = info.hit;
        a_wr_need = info.hit;
        a_rd_addr = AAddrW'(info.slot);
        if (len_q < LenW'(TopLenBin)) begin
          len_d = len_q + 1'b1;
        end
      end
      ActEnd: begin
        bin_d     = len_q;
        b_rd_en   = 1'b1;
        b_wr_need = 1'b1;
        b_rd_addr = BAddrW'(len_q);
        len_d     = '0;
      end
      ActRead: begin
        case (bank)
          BankLen: begin
            if (entry_index_i <= IdxW'(TopLenBin)) begin
              b_rd_en   = 1'b1;
              b_rd_addr = BAddrW'(entry_index_i);
              sel_d     = SelB;
            end
          end
          BankClass: begin
            if (entry_index_i < IdxW'(ClassCount)) begin
              b_rd_en   = 1'b1;
              b_rd_addr = BAddrW'(ClassBase) + BAddrW'(entry_index_i);
              sel_d     = SelB;
            end
          end
          BankChar: begin
            if (entry_index_i < IdxW'(TableSize)) begin
              a_rd_en   = 1'b1;
              a_rd_addr = AAddrW'(entry_index_i);
              sel_d     = SelA;
            end
          end
          default: begin
            sel_d = SelNone;
          end
        endcase
      end
      default: begin
        sel_d = SelNone;
      end
    endcase
  end

  // counter memories, read on accept, written back when the word moves on
  pcs_cnt_mem #(.Depth(ADepth)) u_char_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && a_rd_en),
    .rd_addr_i (a_rd_addr),
    .wr_en_i   (a_wr_en),
    .wr_addr_i (s1_a_addr_q),
    .wr_data_i (a_wr_data),
    .rd_data_o (a_rd_data)
  );

  pcs_cnt_mem #(.Depth(BDepth)) u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && b_rd_en),
    .rd_addr_i (b_rd_addr),
    .wr_en_i   (b_wr_en),
    .wr_addr_i (s1_b_addr_q),
    .wr_data_i (b_wr_data),
    .rd_data_o (b_rd_data)
  );

  // modify and write back
  assign a_wr_en   = s1_adv && s1_a_wr_q;
  assign b_wr_en   = s1_adv && s1_b_wr_q;
  assign a_wr_data = sat_inc(a_rd_data);
  assign b_wr_data = sat_inc(b_rd_data);

  always_comb begin
    case (s1_sel_q)
      SelA:    value = a_rd_data;
      SelB:    value = b_rd_data;
      default: value = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      s1_vld_q  <= 1'b0;
      s1_a_wr_q <= 1'b0;
      s1_b_wr_q <= 1'b0;
      s1_sel_q  <= SelNone;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        len_q     <= len_d;
        s1_vld_q  <= 1'b1;
        s1_a_wr_q <= a_wr_need;
        s1_b_wr_q <= b_wr_need;
        s1_sel_q  <= sel_d;
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
        s1_a_wr_q <= 1'b0;
        s1_b_wr_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_a_addr_q <= a_rd_addr;
      s1_b_addr_q <= b_rd_addr;
      s1_cls_q    <= cls_d;
      s1_hit_q    <= hit_d;
      s1_slot_q   <= slot_d;
      s1_bin_q    <= bin_d;
    end
    if (s1_adv) begin
      out_cls_q  <= s1_cls_q;
      out_hit_q  <= s1_hit_q;
      out_slot_q <= s1_slot_q;
      out_bin_q  <= s1_bin_q;
      out_val_q  <= value;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign char_class_o  = out_cls_q;
  assign table_hit_o   = out_hit_q;
  assign table_slot_o  = out_slot_q;
  assign length_bin_o  = out_bin_q;
  assign count_value_o = out_val_q;

endmodule

@@ rtl/core/pcs_classify.sv @@
// byte classifier: class code and character table slot for one byte
// depends on pcs_pkg

module pcs_classify import pcs_pkg::*; (
  input  logic [CharW-1:0] char_i,
  output cls_info_t        info_o
);

  always_comb begin
    info_o.cls  = ClsOther;
    info_o.hit  = 1'b0;
    info_o.slot = '0;
    if (char_i >= ChLowA && char_i <= ChLowZ) begin
      info_o.cls  = ClsLower;
      info_o.hit  = 1'b1;
      info_o.slot = SlotW'(char_i - ChLowA);
    end else if (char_i >= ChUpA && char_i <= ChUpZ) begin
      info_o.cls  = ClsUpper;
      info_o.hit  = 1'b1;
      info_o.slot = SlotW'(UpperBase) + SlotW'(char_i - ChUpA);
    end else if (char_i >= ChZero && char_i <= ChNine) begin
      info_o.cls  = ClsDigit;
      info_o.hit  = 1'b1;
      // zero sits after nine in the table
      if (char_i == ChZero) begin
        info_o.slot = SlotW'(ZeroSlot);
      end else begin
        info_o.slot = SlotW'(DigitBase) + SlotW'(char_i - ChOne);
      end
    end else begin
      for (int k = 0; k < SymCount; k++) begin
        if (char_i == SymTab[k]) begin
          info_o.cls  = ClsSym;
          info_o.hit  = 1'b1;
          info_o.slot = SlotW'(SymBase + k);
        end
      end
    end
  end

endmodule

@@ rtl/core/pcs_cnt_mem.sv @@
// counter memory: one read and one write port, registered read, valid bits
// for zero after reset, and same-edge write forwarding; depends on pcs_pkg

module pcs_cnt_mem import pcs_pkg::*; #(
  parameter int unsigned Depth = 89,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic [CountBits-1:0] wr_data_i,
  output logic [CountBits-1:0] rd_data_o
);

  logic [CountBits-1:0] mem_q [Depth];
  logic [CountBits-1:0] raw_q;
  logic [CountBits-1:0] fwd_data_q;
  logic [Depth-1:0]     vld_q;
  logic                 vld_rd_q;
  logic                 fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_q      <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= vld_q[rd_addr_i];
        // write landing on the same edge as the read
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q    ? fwd_data_q :
                     vld_rd_q ? raw_q      : '0;

endmodule

@@ tb/password_character_statistics_tb.sv @@
// self-checking testbench for the password character statistics block
// depends on pcs_pkg and the password_character_statistics top level

module password_character_statistics_tb;
  import pcs_pkg::*;

  // run length and handshake pressure
  localparam int RandomWords = 540;
  localparam int IdlePct     = 24;
  localparam int CalmFirst   = 420;   // words in this window see no idling on either side
  localparam int CalmLast    = 540;
  localparam int HoldAt      = 250;   // word count that starts the long receiver hold-off
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 60000;
  localparam int PrintCap    = 40;    // mismatch lines beyond this are only counted

  // character table layout
  localparam int UpperSlot0 = 26;
  localparam int DigitSlot1 = 52;
  localparam int DigitSlot0 = 61;
  localparam int SymSlot0   = 62;
  localparam string SymbolOrder = "!@#$%^&*()-{}[]:;\"'<>./?~` ";

  typedef struct packed {
    action_e          act;
    logic [CharW-1:0] ch;
    bank_e            bank;
    logic [IdxW-1:0]  idx;
  } stat_word_t;

  typedef struct packed {
    logic [ClassW-1:0]    cls;
    logic                 hit;
    logic [SlotW-1:0]     slot;
    logic [LenW-1:0]      bin;
    logic [CountBits-1:0] value;
  } stat_res_t;

  typedef struct packed {
    stat_word_t word;
    int         rep;
    bit         known;
    stat_res_t  want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ActionW-1:0]   action_i;
  logic [CharW-1:0]     char_code_i;
  logic [BankW-1:0]     bank_i;
  logic [IdxW-1:0]      entry_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ClassW-1:0]    char_class_o;
  logic                 table_hit_o;
  logic [SlotW-1:0]     table_slot_o;
  logic [LenW-1:0]      length_bin_o;
  logic [CountBits-1:0] count_value_o;

  password_character_statistics i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .char_code_i   (char_code_i),
    .bank_i        (bank_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_class_o  (char_class_o),
    .table_hit_o   (table_hit_o),
    .table_slot_o  (table_slot_o),
    .length_bin_o  (length_bin_o),
    .count_value_o (count_value_o)
  );

  // predicted counter state, mirrors the block
  logic [CountBits-1:0] len_tally   [TopLenBin+1];
  logic [CountBits-1:0] class_tally [ClassCount];
  logic [CountBits-1:0] char_tally  [TableSize];
  int unsigned          pw_len;

  stat_res_t pending_stats [$];
  dir_row_t  dir_rows      [$];

  int  n_sent, n_feeds, n_ends, n_reads, n_checked, n_errors, n_cycles;
  bit  calm;
  bit  hold_go, hold_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle counter doubles as the watchdog
  initial n_cycles = 0;
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", n_cycles,
               pending_stats.size());
      $display("password_character_statistics regression: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    if (n_errors < PrintCap) begin
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h", n_cycles, what, want, got);
    end
    n_errors++;
  endtask

  // class, table hit and slot of one byte
  function automatic void sort_byte(input logic [CharW-1:0] c, output logic [ClassW-1:0] cls,
                                    output logic hit, output logic [SlotW-1:0] slot);
    cls  = ClsOther;
    hit  = 1'b0;
    slot = '0;
    if (c >= "a" && c <= "z") begin
      cls  = ClsLower;
      hit  = 1'b1;
      slot = SlotW'(c - "a");
    end else if (c >= "A" && c <= "Z") begin
      cls  = ClsUpper;
      hit  = 1'b1;
      slot = SlotW'(UpperSlot0 + (c - "A"));
    end else if (c >= "0" && c <= "9") begin
      cls  = ClsDigit;
      hit  = 1'b1;
      slot = (c == "0") ? SlotW'(DigitSlot0) : SlotW'(DigitSlot1 + (c - "1"));
    end else begin
      for (int k = 0; k < SymbolOrder.len(); k++) begin
        if (SymbolOrder[k] == c) begin
          cls  = ClsSym;
          hit  = 1'b1;
          slot = SlotW'(SymSlot0 + k);
        end
      end
    end
  endfunction

  // applies one accepted word to the predicted counters and returns its result
  function automatic stat_res_t tally_word(input stat_word_t w);
    stat_res_t r;
    logic [ClassW-1:0] cls;
    logic hit;
    logic [SlotW-1:0] slot;
    r = '0;
    case (w.act)
      ActFeed: begin
        sort_byte(w.ch, cls, hit, slot);
        r.cls  = cls;
        r.hit  = hit;
        r.slot = slot;
        if (~&class_tally[cls]) class_tally[cls]++;
        if (hit && ~&char_tally[slot]) char_tally[slot]++;
        if (pw_len < TopLenBin) pw_len++;
      end
      ActEnd: begin
        r.bin = LenW'(pw_len);
        if (~&len_tally[pw_len]) len_tally[pw_len]++;
        pw_len = 0;
      end
      ActRead: begin
        // out-of-range bank or index reads zero
        if (w.bank == BankLen && w.idx <= TopLenBin) r.value = len_tally[w.idx];
        else if (w.bank == BankClass && w.idx < ClassCount) r.value = class_tally[w.idx];
        else if (w.bank == BankChar && w.idx < TableSize) r.value = char_tally[w.idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  // directed rows, checked against the predictor
  task automatic row_pred(input action_e act, input logic [CharW-1:0] ch, input bank_e bank,
                          input int idx, input int rep);
    dir_row_t row;
    row.word  = '{act: act, ch: ch, bank: bank, idx: IdxW'(idx)};
    row.rep   = rep;
    row.known = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  // directed rows whose result is written out by hand
  task automatic row_known(input action_e act, input logic [CharW-1:0] ch, input bank_e bank,
                           input int idx, input class_e cls, input bit hit, input int slot,
                           input int bin, input int value);
    dir_row_t row;
    row.word  = '{act: act, ch: ch, bank: bank, idx: IdxW'(idx)};
    row.rep   = 1;
    row.known = 1'b1;
    row.want  = '{cls: cls, hit: hit, slot: SlotW'(slot), bin: LenW'(bin),
                  value: CountBits'(value)};
    dir_rows.push_back(row);
  endtask

  // offers one word, waits for the accept, then records what should come back
  task automatic send_word(input stat_word_t w, input bit known, input stat_res_t want);
    stat_res_t guess;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= w.act;
    char_code_i   <= w.ch;
    bank_i        <= w.bank;
    entry_index_i <= w.idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = tally_word(w);
    pending_stats.push_back(known ? want : guess);
    n_sent++;
    case (w.act)
      ActFeed: n_feeds++;
      ActEnd:  n_ends++;
      ActRead: n_reads++;
      default: ;
    endcase
    calm = (n_sent >= CalmFirst && n_sent < CalmLast);
    if (n_sent == HoldAt) hold_go = 1'b1;
    @(negedge clk_i);
  endtask

  // random word with all fields random, action given
  function automatic stat_word_t any_word(input action_e act);
    stat_word_t w;
    w.act  = act;
    w.ch   = CharW'($urandom_range(0, 255));
    w.bank = bank_e'($urandom_range(0, 3));
    w.idx  = IdxW'($urandom_range(0, 127));
    return w;
  endfunction

  // receiver side: random stalls, one long hold-off so the pipe backs up into the input
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : check_results
    stat_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        flag_mismatch("result with nothing pending, count_value", 64'd0, 64'(count_value_o));
      end else begin
        want = pending_stats.pop_front();
        if (char_class_o !== want.cls) begin
          flag_mismatch("char_class", 64'(want.cls), 64'(char_class_o));
        end
        if (table_hit_o !== want.hit) flag_mismatch("table_hit", 64'(want.hit), 64'(table_hit_o));
        if (table_slot_o !== want.slot) begin
          flag_mismatch("table_slot", 64'(want.slot), 64'(table_slot_o));
        end
        if (length_bin_o !== want.bin) begin
          flag_mismatch("length_bin", 64'(want.bin), 64'(length_bin_o));
        end
        if (count_value_o !== want.value) begin
          flag_mismatch("count_value", 64'(want.value), 64'(count_value_o));
        end
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    stat_word_t w;
    int roll, plen;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ActFeed;
    char_code_i   = '0;
    bank_i        = BankLen;
    entry_index_i = '0;
    n_sent = 0; n_feeds = 0; n_ends = 0; n_reads = 0; n_checked = 0; n_errors = 0;
    calm = 1'b0; hold_go = 1'b0; hold_done = 1'b0;
    pw_len = 0;
    foreach (len_tally[k]) len_tally[k] = '0;
    foreach (class_tally[k]) class_tally[k] = '0;
    foreach (char_tally[k]) char_tally[k] = '0;

    // counters read zero straight out of reset
    row_known(ActRead, 8'h00, BankLen, 0, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankClass, ClassCount - 1, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankChar, TableSize - 1, ClsLower, 0, 0, 0, 0);
    // empty password lands in bin zero
    row_known(ActEnd, 8'hff, BankNone, 127, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankLen, 0, ClsLower, 0, 0, 0, 1);
    // table edges of every class, then bytes outside the table
    row_known(ActFeed, "a", BankLen, 0, ClsLower, 1, 0, 0, 0);
    row_known(ActFeed, "z", BankLen, 0, ClsLower, 1, 25, 0, 0);
    row_known(ActFeed, "A", BankLen, 0, ClsUpper, 1, 26, 0, 0);
    row_known(ActFeed, "Z", BankLen, 0, ClsUpper, 1, 51, 0, 0);
    row_known(ActFeed, "1", BankLen, 0, ClsDigit, 1, 52, 0, 0);
    row_known(ActFeed, "9", BankLen, 0, ClsDigit, 1, 60, 0, 0);
    row_known(ActFeed, "0", BankLen, 0, ClsDigit, 1, 61, 0, 0);
    row_known(ActFeed, "!", BankLen, 0, ClsSym, 1, 62, 0, 0);
    row_known(ActFeed, " ", BankLen, 0, ClsSym, 1, 88, 0, 0);
    row_known(ActFeed, 8'h00, BankNone, 127, ClsOther, 0, 0, 0, 0);
    row_known(ActFeed, 8'hff, BankNone, 127, ClsOther, 0, 0, 0, 0);
    row_known(ActFeed, 8'h0a, BankLen, 0, ClsOther, 0, 0, 0, 0);
    row_pred(ActEnd, 8'h00, BankLen, 0, 1);
    row_pred(ActRead, 8'h00, BankChar, TableSize - 1, 1);
    // out-of-range reads and the unused action give all zero
    row_known(ActRead, 8'h00, BankNone, 0, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankLen, TopLenBin + 1, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankClass, ClassCount, ClsLower, 0, 0, 0, 0);
    row_known(ActRead, 8'h00, BankChar, 127, ClsLower, 0, 0, 0, 0);
    row_known(ActNone, 8'hff, BankNone, 127, ClsLower, 0, 0, 0, 0);
    // long password saturates into the top bin
    row_pred(ActFeed, "~", BankLen, 0, TopLenBin + 5);
    row_known(ActEnd, 8'h00, BankLen, 0, ClsLower, 0, 0, TopLenBin, 0);
    row_pred(ActRead, 8'h00, BankLen, TopLenBin, 1);
    row_pred(ActRead, 8'h00, BankClass, ClsOther, 1);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].rep; k++) begin
        send_word(dir_rows[r].word, dir_rows[r].known, dir_rows[r].want);
      end
    end

    // random part: mostly whole passwords with reads mixed in, some noise
    while (n_feeds + n_ends + n_reads < RandomWords + dir_rows.size()) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) plen = $urandom_range(0, 12);
        else if (roll < 95) plen = $urandom_range(13, TopLenBin - 1);
        else plen = $urandom_range(TopLenBin, TopLenBin + 10);
        for (int k = 0; k < plen; k++) begin
          w = any_word(ActFeed);
          // mostly printable text, some arbitrary bytes
          if ($urandom_range(0, 99) < 80) w.ch = CharW'($urandom_range(8'h20, 8'h7e));
          send_word(w, 1'b0, '0);
          if ($urandom_range(0, 99) < 8) begin
            w = any_word(ActRead);
            w.bank = bank_e'($urandom_range(0, 2));
            w.idx  = IdxW'($urandom_range(0, TableSize - 1));
            send_word(w, 1'b0, '0);
          end
        end
        send_word(any_word(ActEnd), 1'b0, '0);
      end else if (roll < 88) begin
        w = any_word(ActRead);
        if ($urandom_range(0, 99) < 80) begin
          w.bank = bank_e'($urandom_range(0, 2));
          case (w.bank)
            BankLen:   w.idx = IdxW'($urandom_range(0, TopLenBin));
            BankClass: w.idx = IdxW'($urandom_range(0, ClassCount - 1));
            default:   w.idx = IdxW'($urandom_range(0, TableSize - 1));
          endcase
        end
        send_word(w, 1'b0, '0);
      end else if (roll < 94) begin
        send_word(any_word(ActNone), 1'b0, '0);
      end else if (roll < 97) begin
        // stray end, often an empty password
        send_word(any_word(ActEnd), 1'b0, '0);
      end else begin
        send_word(any_word(ActFeed), 1'b0, '0);
      end
    end

    // final readout of every counter in every bank
    for (int b = 0; b < 3; b++) begin
      for (int k = 0; k < TableSize; k++) begin
        w = any_word(ActRead);
        w.bank = bank_e'(b);
        w.idx  = IdxW'(k);
        if ((b == BankLen && k <= TopLenBin) || (b == BankClass && k < ClassCount) ||
            b == BankChar) begin
          send_word(w, 1'b0, '0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_stats.size() != 0) begin
      flag_mismatch("results left over", 64'd0, 64'(pending_stats.size()));
    end

    $display("covered %0d words: %0d bytes, %0d password ends, %0d counter reads",
             n_sent, n_feeds, n_ends, n_reads);
    $display("%0d results compared, %0d mismatches, %0d cycles", n_checked, n_errors, n_cycles);
    if (n_errors == 0) begin
      $display("password_character_statistics regression: pass");
    end else begin
      $display("password_character_statistics regression: fail");
    end
    $finish;
  end

endmodule
